// ===== hw/rtl/sfdb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfdb_pkg: shared types and constants of the sensor fault monitor
// Field widths, register indexes, health codes and the serial multiplier's
// request and response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package sfdb_pkg;

   // field widths
   localparam int MV_W        = 16;   // sample in millivolts
   localparam int GAIN_W      = 16;   // Q4.12 gain
   localparam int OFS_W       = 21;   // offset
   localparam int VAL_W       = 22;   // scaled value, limits, min, max
   localparam int EN_W        = 2;    // limit enables
   localparam int RUN_W       = 8;    // run counters, debounce count
   localparam int FAULT_W     = 16;   // fault counter
   localparam int SUM_W       = 26;   // burst sum
   localparam int SQS_W       = 48;   // burst square sum (wraps)
   localparam int RANGE_W     = VAL_W + 1;
   localparam int SCALE_SHIFT = 12;
   localparam int Q_W         = MV_W + GAIN_W + 1 - SCALE_SHIFT;

   // shared shift-add multiplier
   localparam int MUL_A_W = 51;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = 58;

   // ports
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   // parameter defaults
   localparam int BURST_SAMPLES_DEF  = 16;
   localparam int RECOVERY_COUNT_DEF = 3;

   // variance is weighed against the square of a tenth of the range
   localparam int VAR_SCALE = 100;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(4096);
   localparam logic [RUN_W-1:0]  DEBOUNCE_RESET = RUN_W'(3);
   localparam logic [RUN_W-1:0]  RUN_SAT        = {RUN_W{1'b1}};
   localparam logic [FAULT_W-1:0] FAULT_SAT     = {FAULT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN       = 3'd0,
      CSR_OFFSET     = 3'd1,
      CSR_LOW_LIMIT  = 3'd2,
      CSR_HIGH_LIMIT = 3'd3,
      CSR_ENABLES    = 3'd4,
      CSR_DEBOUNCE   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      HEALTH_OK     = 2'd0,
      HEALTH_WARN   = 2'd1,
      HEALTH_INVEST = 2'd2,
      HEALTH_FAULT  = 2'd3
   } health_type;

   typedef struct packed {
      logic [GAIN_W-1:0]       gain;
      logic signed [OFS_W-1:0] offset;
      logic signed [VAL_W-1:0] low_limit;
      logic signed [VAL_W-1:0] high_limit;
      logic [EN_W-1:0]         limit_enables;
      logic [RUN_W-1:0]        debounce_count;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] prod;
   } mul_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sfdb_serial_mul.sv =====
// ----------------------------------------------------------------------------
// sfdb_serial_mul: shift-add multiplier, one multiplier bit per cycle
// Unsigned. Stops as soon as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdb_serial_mul import sfdb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type mul_req,
   output mul_rsp_type      mul_rsp
);

   logic               run_ff, run_in;
   logic [MUL_P_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [MUL_P_W-1:0] acc_ff, acc_in;

   always_comb begin
      run_in = run_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (mul_req.start) begin
         run_in = 1'b1;
         a_in   = MUL_P_W'(mul_req.a);
         b_in   = mul_req.b;
         acc_in = '0;
      end else if (run_ff) begin
         if (b_ff == '0) begin
            run_in = 1'b0;
         end else begin
            acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done = run_ff && (b_ff == '0);
   assign mul_rsp.prod = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfdb_csr.sv =====
// ----------------------------------------------------------------------------
// sfdb_csr: configuration registers
// Index-addressed write port; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdb_csr import sfdb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN:       cfg_in.gain           = csr_data[GAIN_W-1:0];
            CSR_OFFSET:     cfg_in.offset         = csr_data[OFS_W-1:0];
            CSR_LOW_LIMIT:  cfg_in.low_limit      = csr_data[VAL_W-1:0];
            CSR_HIGH_LIMIT: cfg_in.high_limit     = csr_data[VAL_W-1:0];
            CSR_ENABLES:    cfg_in.limit_enables  = csr_data[EN_W-1:0];
            CSR_DEBOUNCE:   cfg_in.debounce_count = csr_data[RUN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain           <= GAIN_RESET;
         cfg_ff.offset         <= '0;
         cfg_ff.low_limit      <= '0;
         cfg_ff.high_limit     <= '0;
         cfg_ff.limit_enables  <= '0;
         cfg_ff.debounce_count <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_fault_debounce_burst_check_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_fault_debounce_burst_check_unit: single-channel sensor fault monitor
// Scales each sample, checks it against the enabled limits, debounces
// excursions and runs a burst investigation that gives a fault, warning or
// ok verdict.
// ----------------------------------------------------------------------------
//
//  channel  direction  beat contents (low bit first)
//  -------  ---------  ---------------------------------------------------------
//  req_     in         tdata: sample_mv[15:0]
//  rsp_     out        tdata: scaled_value, health, outside_limits, burst_sample,
//                      burst_finished, fault_raised, fault_cleared, fault_total
//  csr_     in         index 0..5, data: register value in the low bits
//
//  One sample is in work at a time; req_tready is high only while idle.
//  A sample's products come from the shared shift-add multiplier (one
//  multiplier bit a cycle): the gain product always, the square for a
//  burst sample, the spread check products for the last burst sample when both
//  limits are on and no fault is found. Synchronous active-high reset,
//  no clearing pass. A stalled rsp_ holds its beat in the output register;
//  the next sample is taken meanwhile and waits at the end of its work.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_fault_debounce_burst_check_unit import sfdb_pkg::*; #(
   parameter int BURST_SAMPLES  = BURST_SAMPLES_DEF,   // 2..16
   parameter int RECOVERY_COUNT = RECOVERY_COUNT_DEF   // 1..255
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample in
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] sample_mv
   // result out
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [21:0] scaled_value,
                                                   // [23:22] health,
                                                   // [24] outside_limits,
                                                   // [25] burst_sample,
                                                   // [26] burst_finished,
                                                   // [27] fault_raised,
                                                   // [28] fault_cleared,
                                                   // [44:29] fault_total,
                                                   // [47:45] zero
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int BURST_W = $clog2(BURST_SAMPLES + 1);
   localparam int N_SQ    = BURST_SAMPLES * BURST_SAMPLES;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_SCALE    = 12'b0000_0000_0010,  // |mv| * gain
      ST_OFFSET   = 12'b0000_0000_0100,  // add offset, saturate
      ST_CLASSIFY = 12'b0000_0000_1000,  // limit check; run counters outside a burst
      ST_SQUARE   = 12'b0000_0001_0000,  // |v|^2, burst accumulate
      ST_CHECK    = 12'b0000_0010_0000,  // fault verdict
      ST_SUMSQ    = 12'b0000_0100_0000,  // sum^2
      ST_SPREAD   = 12'b0000_1000_0000,  // N * square sum
      ST_RANGE    = 12'b0001_0000_0000,  // range^2
      ST_LIMIT    = 12'b0010_0000_0000,  // N^2 * range^2
      ST_HUNDRED  = 12'b0100_0000_0000,  // scaled spread, warning compare
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   cfg_type     cfg;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   sfdb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfdb_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // control and monitor state
   state_type             state_ff, state_in;
   logic [RUN_W-1:0]      bad_run_ff, bad_run_in;
   logic [RUN_W-1:0]      good_run_ff, good_run_in;
   health_type            health_ff, health_in;
   logic [FAULT_W-1:0]    faults_ff, faults_in;
   logic [BURST_W-1:0]    burst_left_ff, burst_left_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQS_W-1:0]      sumsq_ff, sumsq_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [VAL_W-1:0] max_ff, max_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-sample working registers
   logic                  mv_neg_ff, mv_neg_in;
   logic signed [Q_W-1:0] q_ff, q_in;
   logic signed [VAL_W-1:0] v_ff, v_in;
   logic                  outside_ff, outside_in;
   logic                  bsample_ff, bsample_in;
   logic                  bdone_ff, bdone_in;
   logic                  raised_ff, raised_in;
   logic                  cleared_ff, cleared_in;
   logic [MUL_A_W-1:0]    tmp_ff, tmp_in;    // sum^2, then spread
   logic [MUL_P_W-1:0]    rhs_ff, rhs_in;    // N^2 * range^2
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // datapath helpers
   logic                    lo_en, hi_en;
   logic signed [VAL_W-1:0] low_lim, high_lim;
   logic signed [OFS_W-1:0] ofs;
   logic [MV_W-1:0]         mv_mag;
   logic [MV_W+GAIN_W-1:0]  p_mag;
   logic [MV_W+GAIN_W:0]    p_round;
   logic [Q_W-1:0]          q_ceil, q_floor;
   logic signed [VAL_W:0]   o_sum;
   logic signed [VAL_W-1:0] v_sat;
   logic [VAL_W-1:0]        v_u, v_mag;
   logic [SUM_W-1:0]        sum_u, s_mag;
   logic [RANGE_W-1:0]      diff, range_mag;
   logic                    outside_c, not_fault;
   logic [RUN_W-1:0]        bad_next, good_next;
   logic                    rsp_free;

   always_comb begin
      lo_en    = cfg.limit_enables[0];
      hi_en    = cfg.limit_enables[1];
      low_lim  = cfg.low_limit;
      high_lim = cfg.high_limit;
      ofs      = cfg.offset;

      mv_mag = req_tdata[MV_W-1] ? (~req_tdata[MV_W-1:0] + 1'b1) : req_tdata[MV_W-1:0];

      // floor division by 4096 of the signed product
      p_mag   = mul_rsp.prod[MV_W+GAIN_W-1:0];
      p_round = {1'b0, p_mag} + (MV_W+GAIN_W+1)'((1 << SCALE_SHIFT) - 1);
      q_ceil  = p_round[MV_W+GAIN_W:SCALE_SHIFT];
      q_floor = {1'b0, p_mag[MV_W+GAIN_W-1:SCALE_SHIFT]};

      o_sum = (VAL_W+1)'(q_ff) + (VAL_W+1)'(ofs);
      if (o_sum[VAL_W] != o_sum[VAL_W-1]) begin
         v_sat = o_sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         v_sat = o_sum[VAL_W-1:0];
      end

      v_u   = v_ff;
      v_mag = v_u[VAL_W-1] ? (~v_u + 1'b1) : v_u;
      sum_u = sum_ff;
      s_mag = sum_u[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;
      diff  = {high_lim[VAL_W-1], high_lim} - {low_lim[VAL_W-1], low_lim};
      range_mag = diff[RANGE_W-1] ? (~diff + 1'b1) : diff;

      outside_c = (lo_en && (v_ff < low_lim)) || (hi_en && (v_ff > high_lim));
      not_fault = (lo_en && (min_ff >= low_lim)) || (hi_en && (max_ff <= high_lim));

      bad_next  = (bad_run_ff == RUN_SAT) ? RUN_SAT : bad_run_ff + 1'b1;
      good_next = (good_run_ff == RUN_SAT) ? RUN_SAT : good_run_ff + 1'b1;

      rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in      = state_ff;
      bad_run_in    = bad_run_ff;
      good_run_in   = good_run_ff;
      health_in     = health_ff;
      faults_in     = faults_ff;
      burst_left_in = burst_left_ff;
      sum_in        = sum_ff;
      sumsq_in      = sumsq_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      mv_neg_in     = mv_neg_ff;
      q_in          = q_ff;
      v_in          = v_ff;
      outside_in    = outside_ff;
      bsample_in    = bsample_ff;
      bdone_in      = bdone_ff;
      raised_in     = raised_ff;
      cleared_in    = cleared_ff;
      tmp_in        = tmp_ff;
      rhs_in        = rhs_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mv_neg_in     = req_tdata[MV_W-1];
               outside_in    = 1'b0;
               bsample_in    = 1'b0;
               bdone_in      = 1'b0;
               raised_in     = 1'b0;
               cleared_in    = 1'b0;
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(mv_mag);
               mul_req.b     = MUL_B_W'(cfg.gain);
               state_in      = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_rsp.done) begin
               q_in     = mv_neg_ff ? (~q_ceil + 1'b1) : q_floor;
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            v_in     = v_sat;
            state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            outside_in = outside_c;
            state_in   = ST_DONE;
            if (burst_left_ff != '0) begin
               bsample_in    = 1'b1;
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(v_mag);
               mul_req.b     = MUL_B_W'(v_mag);
               state_in      = ST_SQUARE;
            end else if (cfg.limit_enables != '0) begin
               if (outside_c) begin
                  good_run_in = '0;
                  bad_run_in  = bad_next;
                  // bad_next is never zero, so a debounce count of 0 acts as 1
                  if ((bad_next >= cfg.debounce_count) && (health_ff == HEALTH_OK)) begin
                     health_in     = HEALTH_INVEST;
                     burst_left_in = BURST_W'(BURST_SAMPLES);
                     sum_in        = '0;
                     sumsq_in      = '0;
                     min_in        = VAL_MAX;
                     max_in        = VAL_MIN;
                  end
               end else begin
                  bad_run_in  = '0;
                  good_run_in = good_next;
                  if ((good_next >= RUN_W'(RECOVERY_COUNT)) && (health_ff != HEALTH_OK)) begin
                     cleared_in = (health_ff == HEALTH_FAULT);
                     health_in  = HEALTH_OK;
                  end
               end
            end
         end
         ST_SQUARE: begin
            if (mul_rsp.done) begin
               sum_in        = sum_ff + SUM_W'(v_ff);
               sumsq_in      = sumsq_ff + mul_rsp.prod[SQS_W-1:0];
               min_in        = (v_ff < min_ff) ? v_ff : min_ff;
               max_in        = (v_ff > max_ff) ? v_ff : max_ff;
               burst_left_in = burst_left_ff - 1'b1;
               if (burst_left_ff == BURST_W'(1)) begin
                  bdone_in = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CHECK: begin
            if (!not_fault) begin
               health_in = HEALTH_FAULT;
               raised_in = 1'b1;
               faults_in = (faults_ff == FAULT_SAT) ? FAULT_SAT : faults_ff + 1'b1;
               state_in  = ST_DONE;
            end else if (lo_en && hi_en) begin
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(s_mag);
               mul_req.b     = s_mag;
               state_in      = ST_SUMSQ;
            end else begin
               health_in  = HEALTH_OK;
               bad_run_in = '0;
               state_in   = ST_DONE;
            end
         end
         ST_SUMSQ: begin
            if (mul_rsp.done) begin
               tmp_in        = mul_rsp.prod[MUL_A_W-1:0];
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(sumsq_ff);
               mul_req.b     = MUL_B_W'(BURST_SAMPLES);
               state_in      = ST_SPREAD;
            end
         end
         ST_SPREAD: begin
            if (mul_rsp.done) begin
               // N * square sum never falls below sum^2
               tmp_in        = mul_rsp.prod[MUL_A_W-1:0] - tmp_ff;
               mul_req.start = 1'b1;
               mul_req.a     = MUL_A_W'(range_mag);
               mul_req.b     = MUL_B_W'(range_mag);
               state_in      = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_rsp.prod[MUL_A_W-1:0];
               mul_req.b     = MUL_B_W'(N_SQ);
               state_in      = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            if (mul_rsp.done) begin
               rhs_in        = mul_rsp.prod;
               mul_req.start = 1'b1;
               mul_req.a     = tmp_ff;
               mul_req.b     = MUL_B_W'(VAR_SCALE);
               state_in      = ST_HUNDRED;
            end
         end
         ST_HUNDRED: begin
            if (mul_rsp.done) begin
               if (mul_rsp.prod > rhs_ff) begin
                  health_in = HEALTH_WARN;
               end else begin
                  health_in  = HEALTH_OK;
                  bad_run_in = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({faults_ff, cleared_ff, raised_ff, bdone_ff,
                                           bsample_ff, outside_ff, health_ff, v_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bad_run_ff    <= '0;
         good_run_ff   <= '0;
         health_ff     <= HEALTH_OK;
         faults_ff     <= '0;
         burst_left_ff <= '0;
         sum_ff        <= '0;
         sumsq_ff      <= '0;
         min_ff        <= VAL_MAX;
         max_ff        <= VAL_MIN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bad_run_ff    <= bad_run_in;
         good_run_ff   <= good_run_in;
         health_ff     <= health_in;
         faults_ff     <= faults_in;
         burst_left_ff <= burst_left_in;
         sum_ff        <= sum_in;
         sumsq_ff      <= sumsq_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mv_neg_ff   <= mv_neg_in;
      q_ff        <= q_in;
      v_ff        <= v_in;
      outside_ff  <= outside_in;
      bsample_ff  <= bsample_in;
      bdone_ff    <= bdone_in;
      raised_ff   <= raised_in;
      cleared_ff  <= cleared_in;
      tmp_ff      <= tmp_in;
      rhs_ff      <= rhs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
